>>> rtl/core/gfcm_pkg.sv
// ----------------------------------------------------------------------------
// gfcm_pkg
// Shared types and constants of the grey false-colour map.
// ----------------------------------------------------------------------------
package gfcm_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned PAL_W      = 3;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // Palette codes. Codes six and seven carry no name and act as greyscale.
  typedef enum logic [PAL_W-1:0] {
    PAL_BLACK_GREY_RED  = 3'd0,
    PAL_BLUE_GREY_WHITE = 3'd1,
    PAL_BLUE_GREY_RED   = 3'd2,
    PAL_RAINBOW         = 3'd3,
    PAL_CYAN_BLACK_YEL  = 3'd4,
    PAL_GREYSCALE       = 3'd5
  } pal_e;

  localparam cfg_idx_t CFG_PALETTE = 2'd0;
  localparam cfg_idx_t CFG_INVERSE = 2'd1;

  // Load enables of the three pipeline stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } pipe_ctl_t;

  function automatic pix_t clamp8(input logic signed [10:0] v);
    pix_t res;
    if (v < 11'sd0) begin
      res = 8'd0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/gfcm_datapath.sv
// ----------------------------------------------------------------------------
// gfcm_datapath
// Three register stages: input capture, palette arithmetic, selection and
// clamping into the output register.
// ----------------------------------------------------------------------------
module gfcm_datapath (
  input  logic               clk,
  input  gfcm_pkg::pipe_ctl_t ctl,
  input  logic [2:0]         palette,
  input  logic               inverse_mode,
  input  gfcm_pkg::pix_t     grey_in,
  input  gfcm_pkg::pix_t     red_in,
  input  gfcm_pkg::pix_t     green_in,
  input  gfcm_pkg::pix_t     blue_in,
  output gfcm_pkg::pix_t     red_out,
  output gfcm_pkg::pix_t     green_out,
  output gfcm_pkg::pix_t     blue_out,
  output gfcm_pkg::pix_t     grey_out,
  output logic               no_inverse
);
  import gfcm_pkg::*;

  // Stage 1: captured item and mode.
  logic [2:0] s1_pal_r;
  logic       s1_inv_r;
  pix_t       s1_grey_r, s1_red_r, s1_green_r, s1_blue_r;

  // Stage 2: intermediate values.
  logic [2:0]         s2_pal_r, s2_pal_nxt;
  logic               s2_inv_r, s2_inv_nxt;
  pix_t               s2_grey_r, s2_grey_nxt;
  pix_t               s2_red_r, s2_red_nxt;
  pix_t               s2_blue_r, s2_blue_nxt;
  logic [1:0]         s2_bgr_band_r, s2_bgr_band_nxt;
  pix_t               s2_bgr_y_r, s2_bgr_y_nxt;
  logic [1:0]         s2_rbw_band_r, s2_rbw_band_nxt;
  pix_t               s2_rbw_y_r, s2_rbw_y_nxt;
  logic signed [10:0] s2_cby_d_r, s2_cby_d_nxt;
  logic signed [10:0] s2_cby_e_r, s2_cby_e_nxt;
  logic [16:0]        s2_ibgr_prod_r, s2_ibgr_prod_nxt;
  logic [14:0]        s2_irbw_n_r, s2_irbw_n_nxt;
  logic [2:0]         s2_irbw_band_r, s2_irbw_band_nxt;
  logic [16:0]        s2_icby_prod_r, s2_icby_prod_nxt;
  logic [1:0]         s2_icby_sel_r, s2_icby_sel_nxt;

  // Stage 3: output register.
  pix_t red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt, grey_r, grey_nxt;
  logic none_r, none_nxt;

  // Stage 1 helpers.
  pix_t               rem85;
  logic [13:0]        rbw_prod;
  pix_t               rbw_inv;
  logic signed [10:0] gs, ga;
  logic [1:0]         ibgr_band;
  pix_t               ibgr_y;
  pix_t               irbw_y;
  logic [8:0]         icby_x;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      s1_pal_r   <= palette;
      s1_inv_r   <= inverse_mode;
      s1_grey_r  <= grey_in;
      s1_red_r   <= red_in;
      s1_green_r <= green_in;
      s1_blue_r  <= blue_in;
    end
  end

  always_comb begin
    s2_pal_nxt   = s1_pal_r;
    s2_inv_nxt   = s1_inv_r;
    s2_grey_nxt  = s1_grey_r;
    s2_red_nxt   = s1_red_r;
    s2_blue_nxt  = s1_blue_r;

    // Blue-grey-red: band is grey / 85, the top band holds grey 255 alone.
    if (s1_grey_r == 8'd255) begin
      s2_bgr_band_nxt = 2'd3;
      rem85           = 8'd0;
    end else if (s1_grey_r >= 8'd170) begin
      s2_bgr_band_nxt = 2'd2;
      rem85           = s1_grey_r - 8'd170;
    end else if (s1_grey_r >= 8'd85) begin
      s2_bgr_band_nxt = 2'd1;
      rem85           = s1_grey_r - 8'd85;
    end else begin
      s2_bgr_band_nxt = 2'd0;
      rem85           = s1_grey_r;
    end
    s2_bgr_y_nxt = {rem85[6:0], 1'b0} + rem85;

    // Rainbow: y = floor(255 * m / 64) with m the low six bits of 255 - grey.
    rbw_inv          = ~s1_grey_r;
    rbw_prod         = {rbw_inv[5:0], 8'd0} - {8'd0, rbw_inv[5:0]};
    s2_rbw_band_nxt  = rbw_inv[7:6];
    s2_rbw_y_nxt     = rbw_prod[13:6];

    // Cyan-black-yellow.
    gs           = $signed({3'b000, s1_grey_r}) - 11'sd128;
    ga           = (gs < 11'sd0) ? -gs : gs;
    s2_cby_d_nxt = gs * 11'sd3;
    s2_cby_e_nxt = (ga - 11'sd42) * 11'sd3;

    // Inverse blue-grey-red: 85 * (256 * band + y) + 255.
    if (s1_red_r == 8'd0) begin
      ibgr_band = 2'd0;
      ibgr_y    = ~s1_blue_r;
    end else if (s1_red_r == 8'd255) begin
      ibgr_band = 2'd2;
      ibgr_y    = ~s1_blue_r;
    end else begin
      ibgr_band = 2'd1;
      ibgr_y    = s1_blue_r;
    end
    s2_ibgr_prod_nxt = {7'd0, ibgr_band, ibgr_y} * 17'd85 + 17'd255;

    // Inverse rainbow: numerator of ceil(64 * y / 255).
    if (s1_red_r != 8'd0) begin
      if (s1_red_r == 8'd255) begin
        s2_irbw_band_nxt = 3'd0;
        irbw_y           = s1_green_r;
      end else begin
        s2_irbw_band_nxt = 3'd1;
        irbw_y           = ~s1_red_r;
      end
    end else if (s1_green_r != 8'd0) begin
      if (s1_green_r == 8'd255) begin
        s2_irbw_band_nxt = 3'd2;
        irbw_y           = s1_blue_r;
      end else begin
        s2_irbw_band_nxt = 3'd3;
        irbw_y           = ~s1_green_r;
      end
    end else begin
      s2_irbw_band_nxt = 3'd4;
      irbw_y           = 8'd255;
    end
    s2_irbw_n_nxt = {1'b0, irbw_y, 6'd0} + 15'd254;

    // Inverse cyan-black-yellow: x / 3 is taken as (x * 171) >> 9, exact below 512.
    if (s1_red_r != 8'd0) begin
      if (s1_red_r != 8'd255) begin
        s2_icby_sel_nxt = 2'd0;
        icby_x          = {1'b0, s1_red_r};
      end else begin
        s2_icby_sel_nxt = 2'd1;
        icby_x          = {1'b0, s1_green_r};
      end
    end else if (s1_blue_r != 8'd255) begin
      s2_icby_sel_nxt = 2'd2;
      icby_x          = {1'b0, s1_blue_r} + 9'd2;
    end else begin
      s2_icby_sel_nxt = 2'd3;
      icby_x          = {1'b0, s1_green_r} + 9'd2;
    end
    s2_icby_prod_nxt = {8'd0, icby_x} * 17'd171;
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      s2_pal_r       <= s2_pal_nxt;
      s2_inv_r       <= s2_inv_nxt;
      s2_grey_r      <= s2_grey_nxt;
      s2_red_r       <= s2_red_nxt;
      s2_blue_r      <= s2_blue_nxt;
      s2_bgr_band_r  <= s2_bgr_band_nxt;
      s2_bgr_y_r     <= s2_bgr_y_nxt;
      s2_rbw_band_r  <= s2_rbw_band_nxt;
      s2_rbw_y_r     <= s2_rbw_y_nxt;
      s2_cby_d_r     <= s2_cby_d_nxt;
      s2_cby_e_r     <= s2_cby_e_nxt;
      s2_ibgr_prod_r <= s2_ibgr_prod_nxt;
      s2_irbw_n_r    <= s2_irbw_n_nxt;
      s2_irbw_band_r <= s2_irbw_band_nxt;
      s2_icby_prod_r <= s2_icby_prod_nxt;
      s2_icby_sel_r  <= s2_icby_sel_nxt;
    end
  end

  // Stage 2 helpers.
  pix_t       dbl, bgr_z, rbw_z, half_b;
  logic [15:0] irbw_div;
  logic [8:0] irbw_t;
  logic [6:0] icby_q;
  logic [8:0] icby_v;

  always_comb begin
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    grey_nxt  = 8'd0;
    none_nxt  = 1'b0;

    dbl    = {s2_grey_r[6:0], 1'b0};
    bgr_z  = ~s2_bgr_y_r;
    rbw_z  = ~s2_rbw_y_r;
    half_b = 8'(({1'b0, s2_blue_r} + 9'd1) >> 1);

    // n / 255 as (n + (n >> 8) + 1) >> 8, exact for the range of n here.
    irbw_div = 16'({1'b0, s2_irbw_n_r} + {9'd0, s2_irbw_n_r[14:8]} + 16'd1);
    irbw_t   = {s2_irbw_band_r, 6'd0} + {1'b0, irbw_div[15:8]};

    icby_q = s2_icby_prod_r[15:9];
    unique case (s2_icby_sel_r)
      2'd0:    icby_v = 9'd128 + {2'd0, icby_q};
      2'd1:    icby_v = 9'd170 + {2'd0, icby_q};
      2'd2:    icby_v = 9'd128 - {2'd0, icby_q};
      default: icby_v = 9'd86 - {2'd0, icby_q};
    endcase

    if (s2_inv_r) begin
      unique case (s2_pal_r)
        PAL_BLACK_GREY_RED:
          grey_nxt = (s2_red_r == 8'd255) ? 8'd255 - half_b : {1'b0, s2_red_r[7:1]};
        PAL_BLUE_GREY_WHITE:
          grey_nxt = (s2_red_r == 8'd0) ? 8'd255 - half_b : {1'b1, s2_red_r[7:1]};
        PAL_BLUE_GREY_RED:
          grey_nxt = s2_ibgr_prod_r[16] ? 8'd255 : s2_ibgr_prod_r[15:8];
        PAL_RAINBOW:
          grey_nxt = (irbw_t > 9'd255) ? 8'd0 : 8'(9'd255 - irbw_t);
        PAL_CYAN_BLACK_YEL:
          grey_nxt = clamp8($signed({2'b00, icby_v}));
        default:
          none_nxt = 1'b1;
      endcase
    end else begin
      unique case (s2_pal_r)
        PAL_BLACK_GREY_RED: begin
          // Upper half: 2 * (255 - grey) is 254 minus twice the low seven bits.
          if (s2_grey_r[7]) begin
            red_nxt   = 8'd255;
            green_nxt = 8'd254 - dbl;
            blue_nxt  = 8'd254 - dbl;
          end else begin
            red_nxt   = dbl;
            green_nxt = dbl;
            blue_nxt  = dbl;
          end
        end
        PAL_BLUE_GREY_WHITE: begin
          if (s2_grey_r[7]) begin
            red_nxt   = dbl;
            green_nxt = dbl;
            blue_nxt  = dbl;
          end else begin
            green_nxt = ~dbl;
            blue_nxt  = ~dbl;
          end
        end
        PAL_BLUE_GREY_RED: begin
          unique case (s2_bgr_band_r)
            2'd0: begin
              green_nxt = bgr_z;
              blue_nxt  = bgr_z;
            end
            2'd1: begin
              red_nxt   = s2_bgr_y_r;
              green_nxt = s2_bgr_y_r;
              blue_nxt  = s2_bgr_y_r;
            end
            2'd2: begin
              red_nxt   = 8'd255;
              green_nxt = bgr_z;
              blue_nxt  = bgr_z;
            end
            default: red_nxt = 8'd255;
          endcase
        end
        PAL_RAINBOW: begin
          unique case (s2_rbw_band_r)
            2'd0: begin
              red_nxt   = 8'd255;
              green_nxt = s2_rbw_y_r;
            end
            2'd1: begin
              red_nxt   = rbw_z;
              green_nxt = 8'd255;
            end
            2'd2: begin
              green_nxt = 8'd255;
              blue_nxt  = s2_rbw_y_r;
            end
            default: begin
              green_nxt = rbw_z;
              blue_nxt  = 8'd255;
            end
          endcase
        end
        PAL_CYAN_BLACK_YEL: begin
          red_nxt   = clamp8(s2_cby_d_r);
          green_nxt = clamp8(s2_cby_e_r);
          blue_nxt  = clamp8(-s2_cby_d_r);
        end
        default: begin
          red_nxt   = s2_grey_r;
          green_nxt = s2_grey_r;
          blue_nxt  = s2_grey_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      grey_r  <= grey_nxt;
      none_r  <= none_nxt;
    end
  end

  assign red_out    = red_r;
  assign green_out  = green_r;
  assign blue_out   = blue_r;
  assign grey_out   = grey_r;
  assign no_inverse = none_r;

endmodule

>>> rtl/core/grey_false_colour_map.sv
// ----------------------------------------------------------------------------
// grey_false_colour_map
// Grey level to false colour through one of six palettes, and back.
// ----------------------------------------------------------------------------
// Usage:
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes the palette (index 0) and the direction (index 1, 1 = colour to
//   grey). It is always ready; change it only while no pixel is in flight.
//   The input channel takes one pixel per transfer: grey in forward mode,
//   red, green and blue in inverse mode. Each pixel gives exactly one
//   result on the output channel, in order.
//   A pixel passes the input capture, arithmetic and output stages in turn
//   before it reaches out_valid. Throughput is one pixel per cycle for as
//   long as out_ready stays high.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling; in_ready drops once all three stages
//   hold a pixel, so nothing is dropped or repeated.
//   Synchronous reset (rst_n low) empties the pipeline and sets the palette
//   to black-grey-red in forward mode.
// ----------------------------------------------------------------------------
module grey_false_colour_map (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  gfcm_pkg::cfg_idx_t    cfg_index,
  input  gfcm_pkg::cfg_data_t   cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gfcm_pkg::pix_t        in_grey_in,
  input  gfcm_pkg::pix_t        in_red_in,
  input  gfcm_pkg::pix_t        in_green_in,
  input  gfcm_pkg::pix_t        in_blue_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gfcm_pkg::pix_t        out_red_out,
  output gfcm_pkg::pix_t        out_green_out,
  output gfcm_pkg::pix_t        out_blue_out,
  output gfcm_pkg::pix_t        out_grey_out,
  output logic                  out_no_inverse
);
  import gfcm_pkg::*;

  logic [PAL_W-1:0] palette_r, palette_nxt;
  logic             inverse_r, inverse_nxt;
  logic             v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  pipe_ctl_t        ctl;

  assign cfg_ready = 1'b1;

  always_comb begin
    palette_nxt = palette_r;
    inverse_nxt = inverse_r;
    if (cfg_valid) begin
      if (cfg_index == CFG_PALETTE) begin
        palette_nxt = cfg_data[PAL_W-1:0];
      end else if (cfg_index == CFG_INVERSE) begin
        inverse_nxt = cfg_data[0];
      end
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    ctl.en3 = !v3_r || out_ready;
    ctl.en2 = !v2_r || ctl.en3;
    ctl.en1 = !v1_r || ctl.en2;
    v1_nxt  = ctl.en1 ? in_valid : v1_r;
    v2_nxt  = ctl.en2 ? v1_r : v2_r;
    v3_nxt  = ctl.en3 ? v2_r : v3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_r <= PAL_BLACK_GREY_RED;
      inverse_r <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
    end else begin
      palette_r <= palette_nxt;
      inverse_r <= inverse_nxt;
      v1_r      <= v1_nxt;
      v2_r      <= v2_nxt;
      v3_r      <= v3_nxt;
    end
  end

  assign in_ready  = ctl.en1;
  assign out_valid = v3_r;

  gfcm_datapath u_datapath (
    .clk          (clk),
    .ctl          (ctl),
    .palette      (palette_r),
    .inverse_mode (inverse_r),
    .grey_in      (in_grey_in),
    .red_in       (in_red_in),
    .green_in     (in_green_in),
    .blue_in      (in_blue_in),
    .red_out      (out_red_out),
    .green_out    (out_green_out),
    .blue_out     (out_blue_out),
    .grey_out     (out_grey_out),
    .no_inverse   (out_no_inverse)
  );

endmodule

>>> rtl/core/gfcm_checker.sv
// ----------------------------------------------------------------------------
// gfcm_checker
// Port-level checks of the grey false-colour map, bound to the top level.
// ----------------------------------------------------------------------------
module gfcm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gfcm_pkg::pix_t      out_red_out,
  input gfcm_pkg::pix_t      out_green_out,
  input gfcm_pkg::pix_t      out_blue_out,
  input gfcm_pkg::pix_t      out_grey_out,
  input logic                out_no_inverse
);
  import gfcm_pkg::*;

  // A stalled result keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red_out)
      && $stable(out_green_out) && $stable(out_blue_out)
      && $stable(out_grey_out) && $stable(out_no_inverse))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A result is either a colour or a grey level, never both.
  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_grey_out != 8'd0 || out_no_inverse) |->
      out_red_out == 8'd0 && out_green_out == 8'd0 && out_blue_out == 8'd0)
    else $error("colour and grey both present");

  a_no_inverse_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_inverse |-> out_grey_out == 8'd0)
    else $error("grey returned without an inverse");

  // With the receiver kept ready, a transfer comes out after the capture, arithmetic and output stages.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("pixel did not reach the output in time");

endmodule

bind grey_false_colour_map gfcm_checker u_gfcm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red_out    (out_red_out),
  .out_green_out  (out_green_out),
  .out_blue_out   (out_blue_out),
  .out_grey_out   (out_grey_out),
  .out_no_inverse (out_no_inverse)
);

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grey false-colour map. Pixels go in through a
// bursty sender, results are drained by a receiver that stalls on its own
// pattern, and every result is compared field by field with a local model of
// all palettes in both directions.
// ----------------------------------------------------------------------------
module tb;
  import gfcm_pkg::*;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    pix_t grey;
    logic no_inv;
  } pixel_res_t;

  logic      clk            = 1'b0;
  logic      rst_n          = 1'b0;
  logic      cfg_valid      = 1'b0;
  logic      cfg_ready;
  cfg_idx_t  cfg_index      = '0;
  cfg_data_t cfg_data       = '0;
  logic      in_valid       = 1'b0;
  logic      in_ready;
  pix_t      in_grey_in     = '0;
  pix_t      in_red_in      = '0;
  pix_t      in_green_in    = '0;
  pix_t      in_blue_in     = '0;
  logic      out_valid;
  logic      out_ready      = 1'b0;
  pix_t      out_red_out;
  pix_t      out_green_out;
  pix_t      out_blue_out;
  pix_t      out_grey_out;
  logic      out_no_inverse;

  // Local copy of the two registers, updated on each configuration transfer to either.
  logic [PAL_W-1:0] cur_pal = PAL_BLACK_GREY_RED;
  logic             cur_inv = 1'b0;

  pixel_res_t colour_due[$];
  pixel_res_t want;
  int         bad_pixels = 0;

  // Sender pacing: gap_max of zero means back-to-back transfers.
  int gap_max    = 4;
  int burst_left = 0;

  // Receiver pacing.
  int   stall_pct = 25;
  int   hold_left = 0;
  int   run_left  = 0;
  logic ready_lvl = 1'b1;

  grey_false_colour_map u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_grey_in     (in_grey_in),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_grey_out   (out_grey_out),
    .out_no_inverse (out_no_inverse)
  );

  always #1 clk = ~clk;

  function automatic pix_t sat_u8(input int v);
    if (v < 0) begin
      return 8'd0;
    end
    if (v > 255) begin
      return 8'd255;
    end
    return pix_t'(v);
  endfunction

  function automatic pixel_res_t forward_colour(input logic [PAL_W-1:0] pal, input pix_t gv);
    pixel_res_t c;
    int g, inv, band, y, z, d, a;
    c = '0;
    g = gv;
    case (pal)
      PAL_BLACK_GREY_RED: begin
        if (g >= 128) begin
          c.red   = 8'd255;
          c.green = pix_t'((255 - g) * 2);
          c.blue  = c.green;
        end else begin
          c.red   = pix_t'(g * 2);
          c.green = c.red;
          c.blue  = c.red;
        end
      end
      PAL_BLUE_GREY_WHITE: begin
        if (g >= 128) begin
          c.red   = pix_t'(2 * (g - 128));
          c.green = c.red;
          c.blue  = c.red;
        end else begin
          c.red   = 8'd0;
          c.green = pix_t'(255 - 2 * g);
          c.blue  = c.green;
        end
      end
      PAL_BLUE_GREY_RED: begin
        band = g / 85;
        y    = 3 * (g % 85);
        z    = 255 - y;
        case (band)
          0: begin c.red = 8'd0;   c.green = pix_t'(z); c.blue = pix_t'(z); end
          1: begin c.red = pix_t'(y); c.green = pix_t'(y); c.blue = pix_t'(y); end
          2: begin c.red = 8'd255; c.green = pix_t'(z); c.blue = pix_t'(z); end
          default: begin c.red = 8'd255; c.green = 8'd0; c.blue = 8'd0; end
        endcase
      end
      PAL_RAINBOW: begin
        inv  = 255 - g;
        band = inv / 64;
        y    = (255 * (inv % 64)) / 64;
        z    = 255 - y;
        case (band)
          0: begin c.red = 8'd255;   c.green = pix_t'(y); c.blue = 8'd0; end
          1: begin c.red = pix_t'(z); c.green = 8'd255;   c.blue = 8'd0; end
          2: begin c.red = 8'd0;     c.green = 8'd255;   c.blue = pix_t'(y); end
          default: begin c.red = 8'd0; c.green = pix_t'(z); c.blue = 8'd255; end
        endcase
      end
      PAL_CYAN_BLACK_YEL: begin
        d = 3 * (g - 128);
        a = (g >= 128) ? g - 128 : 128 - g;
        c.red   = sat_u8(d);
        c.green = sat_u8(3 * (a - 42));
        c.blue  = sat_u8(-d);
      end
      default: begin
        c.red   = gv;
        c.green = gv;
        c.blue  = gv;
      end
    endcase
    return c;
  endfunction

  function automatic pixel_res_t recover_grey(input logic [PAL_W-1:0] pal,
                                              input pix_t rv, input pix_t gv, input pix_t bv);
    pixel_res_t c;
    int r, g, b, band, y, v;
    c = '0;
    r = rv;
    g = gv;
    b = bv;
    v = 0;
    case (pal)
      PAL_BLACK_GREY_RED:  v = (r == 255) ? 255 - (b + 1) / 2 : r / 2;
      PAL_BLUE_GREY_WHITE: v = (r == 0) ? 255 - (b + 1) / 2 : r / 2 + 128;
      PAL_BLUE_GREY_RED: begin
        if (r == 0) begin
          band = 0; y = 255 - b;
        end else if (r == 255) begin
          band = 2; y = 255 - b;
        end else begin
          band = 1; y = b;
        end
        v = (85 * (256 * band + y) + 255) / 256;
      end
      PAL_RAINBOW: begin
        if (r > 0) begin
          if (r == 255) begin band = 0; y = g; end
          else begin band = 1; y = 255 - r; end
        end else if (g > 0) begin
          if (g == 255) begin band = 2; y = b; end
          else begin band = 3; y = 255 - g; end
        end else begin
          band = 4; y = 255;
        end
        // This can go below zero and must saturate.
        v = 255 - (64 * band + (64 * y + 254) / 255);
      end
      PAL_CYAN_BLACK_YEL: begin
        if (r > 0) begin
          v = (r < 255) ? 128 + r / 3 : 170 + g / 3;
        end else begin
          v = (b < 255) ? 128 - (b + 2) / 3 : 86 - (g + 2) / 3;
        end
      end
      default: c.no_inv = 1'b1;
    endcase
    if (!c.no_inv) begin
      c.grey = sat_u8(v);
    end
    return c;
  endfunction

  function automatic pixel_res_t predict_pixel(input logic [PAL_W-1:0] pal, input logic inv,
                                               input pix_t gy, input pix_t r,
                                               input pix_t g, input pix_t b);
    pixel_res_t c;
    if (inv) begin
      c = recover_grey(pal, r, g, b);
    end else begin
      c = forward_colour(pal, gy);
    end
    return c;
  endfunction

  // Levels near the band and palette break points, or anything at all.
  function automatic pix_t pick_level();
    pix_t base;
    if ($urandom_range(0, 1) == 0) begin
      return pix_t'($urandom);
    end
    case ($urandom_range(0, 7))
      0: base = 8'd0;
      1: base = 8'd64;
      2: base = 8'd85;
      3: base = 8'd86;
      4: base = 8'd128;
      5: base = 8'd170;
      6: base = 8'd192;
      default: base = 8'd255;
    endcase
    return base + pix_t'($urandom_range(0, 2)) - 8'd1;
  endfunction

  task automatic send_px(input pix_t gy, input pix_t r, input pix_t g, input pix_t b);
    int idle_n;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_grey_in  <= gy;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    do @(posedge clk); while (!in_ready);
    colour_due.push_back(predict_pixel(cur_pal, cur_inv, gy, r, g, b));
    if (gap_max > 0) begin
      if (burst_left > 0) begin
        burst_left--;
      end
      if (burst_left == 0) begin
        idle_n = $urandom_range(1, gap_max);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (idle_n - 1) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  task automatic send_random(input int count);
    pixel_res_t c;
    pix_t r, g, b;
    repeat (count) begin
      // In inverse mode most colours are taken from the palette itself.
      if (cur_inv && $urandom_range(0, 3) != 0) begin
        c = forward_colour(cur_pal, pick_level());
        r = c.red;
        g = c.green;
        b = c.blue;
      end else begin
        r = pick_level();
        g = pick_level();
        b = pick_level();
      end
      send_px(pick_level(), r, g, b);
    end
  endtask

  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (colour_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PALETTE) begin
      cur_pal = val[PAL_W-1:0];
    end else if (idx == CFG_INVERSE) begin
      cur_inv = val[0];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Upper data bits are random; the block must only keep the low bits.
  task automatic set_mode(input logic [PAL_W-1:0] pal, input logic inv);
    cfg_data_t d;
    quiesce();
    d = cfg_data_t'($urandom);
    d[PAL_W-1:0] = pal;
    write_reg(CFG_PALETTE, d);
    d = cfg_data_t'($urandom);
    d[0] = inv;
    write_reg(CFG_INVERSE, d);
  endtask

  task automatic test_reset_defaults();
    // No write yet: black-grey-red, forward, on both sides of the midpoint.
    send_px(8'd127, pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
    send_px(8'd128, pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
  endtask

  task automatic test_forward_edges();
    set_mode(PAL_BLUE_GREY_RED, 1'b0);
    send_px(8'd84, 8'd0, 8'd0, 8'd0);
    send_px(8'd85, 8'd255, 8'd255, 8'd255);
    send_px(8'd255, 8'd0, 8'd0, 8'd0);
    set_mode(PAL_RAINBOW, 1'b0);
    send_px(8'd0, 8'd255, 8'd255, 8'd255);
    send_px(8'd192, 8'd0, 8'd0, 8'd0);
    send_px(8'd255, 8'd0, 8'd0, 8'd0);
    set_mode(PAL_CYAN_BLACK_YEL, 1'b0);
    send_px(8'd86, 8'd0, 8'd0, 8'd0);
    // An unnamed palette code behaves as greyscale.
    set_mode(3'd7, 1'b0);
    send_px(8'd200, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_inverse_cases();
    set_mode(PAL_RAINBOW, 1'b1);
    send_px(8'd0, 8'd0, 8'd0, 8'd77);
    send_px(8'd0, 8'd0, 8'd1, 8'd0);
    set_mode(PAL_CYAN_BLACK_YEL, 1'b1);
    send_px(8'd0, 8'd255, 8'd255, 8'd0);
    send_px(8'd0, 8'd0, 8'd255, 8'd255);
    set_mode(PAL_BLUE_GREY_RED, 1'b1);
    send_px(8'd0, 8'd255, 8'd0, 8'd0);
    set_mode(PAL_GREYSCALE, 1'b1);
    send_px(8'd255, 8'd200, 8'd100, 8'd50);
    set_mode(3'd6, 1'b1);
    send_px(8'd255, 8'd1, 8'd2, 8'd3);
  endtask

  task automatic test_ignored_index();
    set_mode(PAL_BLACK_GREY_RED, 1'b0);
    write_reg(cfg_idx_t'(2), 8'hFF);
    write_reg(cfg_idx_t'(3), 8'hFF);
    send_px(8'd100, 8'd0, 8'd0, 8'd0);
  endtask

  task automatic test_backpressure();
    quiesce();
    gap_max   = 0;
    stall_pct = 0;
    // The receiver holds off while the sender keeps offering pixels.
    hold_left = 40;
    send_random(24);
    gap_max   = 4;
    stall_pct = 25;
  endtask

  task automatic test_random_sweep();
    for (int i = 0; i < 16; i++) begin
      set_mode(logic'(i % 8) ? PAL_W'(i % 8) : PAL_W'(i % 8), i >= 8);
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 12;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
      send_random(106);
    end
  endtask

  // Receiver: random runs of ready and stall, or a long counted hold-off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      if (run_left == 0) begin
        ready_lvl = ($urandom_range(0, 99) >= stall_pct);
        run_left  = $urandom_range(1, 6);
      end
      run_left--;
      out_ready <= ready_lvl;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (colour_due.size() == 0) begin
        bad_pixels++;
        if (bad_pixels <= 10) begin
          $display("%0t: result transfer with nothing expected", $realtime);
        end
      end else begin
        want = colour_due.pop_front();
        if (out_red_out !== want.red || out_green_out !== want.green ||
            out_blue_out !== want.blue || out_grey_out !== want.grey ||
            out_no_inverse !== want.no_inv) begin
          bad_pixels++;
          if (bad_pixels <= 10) begin
            $display("%0t: expected rgb %0d %0d %0d grey %0d none %0d, got %0d %0d %0d %0d %0d",
                     $realtime, want.red, want.green, want.blue, want.grey, want.no_inv,
                     out_red_out, out_green_out, out_blue_out, out_grey_out,
                     out_no_inverse);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_forward_edges();
    test_inverse_cases();
    test_ignored_index();
    test_backpressure();
    test_random_sweep();
    test_backpressure();
    quiesce();
    if (bad_pixels == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
rtl/core/gfcm_pkg.sv
rtl/core/gfcm_datapath.sv
rtl/core/grey_false_colour_map.sv
rtl/core/gfcm_checker.sv
bench/tb.sv
